>>> rtl/bml_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bml_pkg
// Shared types, widths, register codes and reset values of the battery level
// monitor.
// ----------------------------------------------------------------------------
package bml_pkg;

  localparam int ADC_BITS  = 12;
  localparam int FRAC_BITS = 8;
  localparam int ELAPSED_W = 16;
  localparam int LEVEL_W   = 20;
  localparam int TIMER_W   = 17;
  localparam int CFG_IDX_W = 3;

  localparam int AVG_DIVISOR = 10;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};
  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  // scaled sample before saturation, wide enough for the sample and the limit
  localparam int SCALED_W = ADC_BITS + FRAC_BITS;
  localparam int WIDE_W   = (SCALED_W > LEVEL_W) ? SCALED_W : LEVEL_W;

  localparam logic [TIMER_W-1:0] SHORT_INTERVAL_MS = TIMER_W'(5000);
  localparam logic [TIMER_W-1:0] MID_INTERVAL_MS   = TIMER_W'(30000);
  localparam logic [TIMER_W-1:0] LONG_INTERVAL_MS  = TIMER_W'(60000);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OFF_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_THRESHOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_ONE_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_TWO_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_THREE_TOP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORANGE_TOP     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH       = 3'd6;

  localparam logic [LEVEL_W-1:0] RST_OFF_THRESHOLD  = 20'd557457;
  localparam logic [LEVEL_W-1:0] RST_ON_THRESHOLD   = 20'd613202;
  localparam logic [LEVEL_W-1:0] RST_BAND_ONE_TOP   = 20'd668948;
  localparam logic [LEVEL_W-1:0] RST_BAND_TWO_TOP   = 20'd724694;
  localparam logic [LEVEL_W-1:0] RST_BAND_THREE_TOP = 20'd808312;
  localparam logic [LEVEL_W-1:0] RST_ORANGE_TOP     = 20'd780439;
  localparam logic [LEVEL_W-1:0] RST_RED_HIGH       = 20'd891931;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_WENT_LOW  = 2'd1,
    EV_RECOVERED = 2'd2
  } low_event_t;

  typedef enum logic [1:0] {
    LED_RED    = 2'd0,
    LED_ORANGE = 2'd1,
    LED_GREEN  = 2'd2
  } led_t;

  typedef struct packed {
    logic [ADC_BITS-1:0]  adc_sample;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } in_t;

  typedef struct packed {
    logic               remind;
    logic [1:0]         low_event;
    logic               battery_low;
    logic [1:0]         led_color;
    logic [LEVEL_W-1:0] avg_level;
  } out_t;

  // scaled and saturated item between front and back
  typedef struct packed {
    logic                 first;
    logic [LEVEL_W-1:0]   level;
    logic [ELAPSED_W-1:0] elapsed;
  } item_t;

  // averaged item between the two back stages
  typedef struct packed {
    logic [LEVEL_W-1:0]   avg;
    logic [ELAPSED_W-1:0] elapsed;
  } lvl_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] off_threshold;
    logic [LEVEL_W-1:0] on_threshold;
    logic [LEVEL_W-1:0] band_one_top;
    logic [LEVEL_W-1:0] band_two_top;
    logic [LEVEL_W-1:0] band_three_top;
    logic [LEVEL_W-1:0] orange_top;
    logic [LEVEL_W-1:0] red_high;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/battery_level_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// battery_level_monitor
// Averages battery converter samples and derives low flag, reminder and LED.
//
// Input channel in_*: one transfer carries a 12-bit sample and the
// milliseconds since the previous sample. Output channel out_*: one result
// per input, in order. Both channels transfer when valid is high and stall
// is low.
// Throughput is one item per cycle while out_stall is low. An input passes
// the input register, the two-entry queue, the average stage (one 20x21
// reciprocal multiply) and the evaluation stage into the result register.
// While out_stall is high the result holds; the stages behind it and the
// queue keep taking items until they are full, then in_stall rises.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); the
// user must write it only while the block is idle (not enforced); unknown indexes are ignored.
// Synchronous reset restores the register defaults, empties the pipeline,
// clears the low flag and the reminder timer; the first sample after reset
// loads the average directly. No clearing pass is needed.
// ----------------------------------------------------------------------------
module battery_level_monitor #(
  parameter int AVG_DIVISOR = bml_pkg::AVG_DIVISOR
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire bml_pkg::in_t                    in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output bml_pkg::out_t                        out_data,
  input  wire logic                            cfg_we,
  input  wire logic [bml_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bml_pkg::LEVEL_W-1:0]     cfg_wdata
);

  bml_pkg::cfg_t   cfg_r, cfg_nxt;
  bml_pkg::item_t  f_item, q_item;
  bml_pkg::lvl_t   lvl;
  logic            f_valid, f_stall;
  logic            q_valid, q_stall;
  logic            l_valid, l_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bml_pkg::REG_OFF_THRESHOLD:  cfg_nxt.off_threshold  = cfg_wdata;
        bml_pkg::REG_ON_THRESHOLD:   cfg_nxt.on_threshold   = cfg_wdata;
        bml_pkg::REG_BAND_ONE_TOP:   cfg_nxt.band_one_top   = cfg_wdata;
        bml_pkg::REG_BAND_TWO_TOP:   cfg_nxt.band_two_top   = cfg_wdata;
        bml_pkg::REG_BAND_THREE_TOP: cfg_nxt.band_three_top = cfg_wdata;
        bml_pkg::REG_ORANGE_TOP:     cfg_nxt.orange_top     = cfg_wdata;
        bml_pkg::REG_RED_HIGH:       cfg_nxt.red_high       = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.off_threshold  <= bml_pkg::RST_OFF_THRESHOLD;
      cfg_r.on_threshold   <= bml_pkg::RST_ON_THRESHOLD;
      cfg_r.band_one_top   <= bml_pkg::RST_BAND_ONE_TOP;
      cfg_r.band_two_top   <= bml_pkg::RST_BAND_TWO_TOP;
      cfg_r.band_three_top <= bml_pkg::RST_BAND_THREE_TOP;
      cfg_r.orange_top     <= bml_pkg::RST_ORANGE_TOP;
      cfg_r.red_high       <= bml_pkg::RST_RED_HIGH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bml_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (f_valid),
    .item_stall (f_stall),
    .item       (f_item)
  );

  bml_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_stall (f_stall),
    .push_data  (f_item),
    .pop_valid  (q_valid),
    .pop_stall  (q_stall),
    .pop_data   (q_item)
  );

  bml_avg #(
    .AVG_DIVISOR (AVG_DIVISOR)
  ) u_avg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_stall (q_stall),
    .item       (q_item),
    .lvl_valid  (l_valid),
    .lvl_stall  (l_stall),
    .lvl        (lvl)
  );

  bml_eval u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .lvl_valid  (l_valid),
    .lvl_stall  (l_stall),
    .lvl        (lvl),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

>>> rtl/bml_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bml_front
// Input register: scales the sample to counts with fraction bits, saturates,
// and tags the first item after reset.
// ----------------------------------------------------------------------------
module bml_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bml_pkg::in_t  in_data,
  output logic               item_valid,
  input  wire logic          item_stall,
  output bml_pkg::item_t     item
);

  logic                      valid_r, valid_nxt;
  logic                      primed_r, primed_nxt;
  bml_pkg::item_t            item_r, item_nxt;
  logic                      take;
  logic [bml_pkg::WIDE_W-1:0] wide;

  assign in_stall = valid_r && item_stall;
  assign take     = in_valid && !in_stall;

  always_comb begin
    wide = bml_pkg::WIDE_W'(in_data.adc_sample) << bml_pkg::FRAC_BITS;
    item_nxt = item_r;
    if (take) begin
      item_nxt.first   = !primed_r;
      item_nxt.elapsed = in_data.elapsed_ms;
      if (wide > bml_pkg::WIDE_W'(bml_pkg::LEVEL_MAX)) begin
        item_nxt.level = bml_pkg::LEVEL_MAX;
      end else begin
        item_nxt.level = wide[bml_pkg::LEVEL_W-1:0];
      end
    end
    valid_nxt  = take || (valid_r && item_stall);
    primed_nxt = primed_r || take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      primed_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      primed_r <= primed_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

>>> rtl/bml_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bml_queue
// Short FIFO between front and back so either side can stall alone.
// ----------------------------------------------------------------------------
module bml_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_stall,
  input  wire bml_pkg::item_t  push_data,
  output logic                 pop_valid,
  input  wire logic            pop_stall,
  output bml_pkg::item_t       pop_data
);

  localparam int DEPTH = bml_pkg::Q_DEPTH;
  localparam int PW    = bml_pkg::Q_PTR_W;
  localparam int CW    = bml_pkg::Q_CNT_W;

  bml_pkg::item_t   mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             push, pop;

  assign push_stall = (count_r == CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bml_avg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bml_avg
// Back stage one: exponential average, avg +/- |sample - avg| / AVG_DIVISOR,
// quotient by reciprocal multiply; the first item loads the average directly.
// ----------------------------------------------------------------------------
module bml_avg #(
  parameter int AVG_DIVISOR = bml_pkg::AVG_DIVISOR
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  output logic                 item_stall,
  input  wire bml_pkg::item_t  item,
  output logic                 lvl_valid,
  input  wire logic            lvl_stall,
  output bml_pkg::lvl_t        lvl
);

  localparam int LW     = bml_pkg::LEVEL_W;
  // floor(n * M >> SHIFT) == floor(n / D) for every n below 2^LW
  localparam int SHIFT  = LW + $clog2(AVG_DIVISOR);
  localparam int REC_W  = LW + 1;
  localparam int PROD_W = SHIFT + LW;
  localparam longint unsigned REC =
    ((64'd1 << SHIFT) + 64'(AVG_DIVISOR) - 64'd1) / 64'(AVG_DIVISOR);
  localparam logic [REC_W-1:0] REC_C = REC_W'(REC);

  logic               valid_r, valid_nxt;
  logic [LW-1:0]      avg_r, avg_nxt;
  logic [bml_pkg::ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic               take;
  logic               up;
  logic [LW-1:0]      diff;
  logic [PROD_W-1:0]  prod;
  logic [LW-1:0]      step;

  assign item_stall = valid_r && lvl_stall;
  assign take       = item_valid && !item_stall;

  always_comb begin
    up   = (item.level >= avg_r);
    diff = up ? (item.level - avg_r) : (avg_r - item.level);
    prod = PROD_W'(diff) * PROD_W'(REC_C);
    step = prod[SHIFT +: LW];
    avg_nxt     = avg_r;
    elapsed_nxt = elapsed_r;
    if (take) begin
      elapsed_nxt = item.elapsed;
      if (item.first) begin
        avg_nxt = item.level;
      end else if (up) begin
        avg_nxt = avg_r + step;
      end else begin
        avg_nxt = avg_r - step;
      end
    end
    valid_nxt = take || (valid_r && lvl_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      avg_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      avg_r   <= avg_nxt;
    end
    elapsed_r <= elapsed_nxt;
  end

  assign lvl_valid   = valid_r;
  assign lvl.avg     = avg_r;
  assign lvl.elapsed = elapsed_r;

endmodule
`default_nettype wire

>>> rtl/bml_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bml_eval
// Back stage two: low flag with hysteresis, band reminder timer, LED color,
// and the result register.
// ----------------------------------------------------------------------------
module bml_eval (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bml_pkg::cfg_t  cfg,
  input  wire logic           lvl_valid,
  output logic                lvl_stall,
  input  wire bml_pkg::lvl_t  lvl,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bml_pkg::out_t       out_data
);

  localparam int TW = bml_pkg::TIMER_W;

  logic                 valid_r, valid_nxt;
  logic                 flag_r, flag_nxt;
  logic [TW-1:0]        timer_r, timer_nxt;
  bml_pkg::out_t        out_r, out_nxt;
  logic                 take;
  logic [TW:0]          sum;
  logic [TW-1:0]        elapsed_t;
  logic [TW-1:0]        interval;
  logic                 has_band;
  logic                 remind_c;
  bml_pkg::low_event_t  event_c;
  bml_pkg::led_t        led_c;
  logic [bml_pkg::LEVEL_W-1:0] a;

  assign lvl_stall = valid_r && out_stall;
  assign take      = lvl_valid && !lvl_stall;

  always_comb begin
    a         = lvl.avg;
    elapsed_t = TW'(lvl.elapsed);
    sum       = (TW+1)'(timer_r) + (TW+1)'(elapsed_t);

    has_band = 1'b1;
    if (a != '0 && a <= cfg.band_one_top) begin
      interval = bml_pkg::SHORT_INTERVAL_MS;
    end else if (a > cfg.band_one_top && a <= cfg.band_two_top) begin
      interval = bml_pkg::MID_INTERVAL_MS;
    end else if (a > cfg.band_two_top && a <= cfg.band_three_top) begin
      interval = bml_pkg::LONG_INTERVAL_MS;
    end else begin
      interval = '0;
      has_band = 1'b0;
    end

    timer_nxt = sum[TW] ? bml_pkg::TIMER_MAX : sum[TW-1:0];
    remind_c  = has_band && (timer_nxt >= interval);
    if (remind_c) begin
      timer_nxt = '0;
    end

    flag_nxt = flag_r;
    event_c  = bml_pkg::EV_NONE;
    if (a < cfg.off_threshold && !flag_r) begin
      flag_nxt = 1'b1;
      event_c  = bml_pkg::EV_WENT_LOW;
    end else if (a > cfg.on_threshold && flag_r) begin
      flag_nxt = 1'b0;
      event_c  = bml_pkg::EV_RECOVERED;
    end

    if (a > cfg.red_high || a < cfg.band_one_top) begin
      led_c = bml_pkg::LED_RED;
    end else if (a < cfg.orange_top) begin
      led_c = bml_pkg::LED_ORANGE;
    end else begin
      led_c = bml_pkg::LED_GREEN;
    end

    out_nxt.remind      = remind_c;
    out_nxt.low_event   = event_c;
    out_nxt.battery_low = flag_nxt;
    out_nxt.led_color   = led_c;
    out_nxt.avg_level   = a;

    if (!take) begin
      out_nxt   = out_r;
      flag_nxt  = flag_r;
      timer_nxt = timer_r;
    end
    valid_nxt = take || (valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flag_r  <= 1'b0;
      timer_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      flag_r  <= flag_nxt;
      timer_r <= timer_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

  // a reminder restarts the interval timer
  a_remind_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && remind_c |=> timer_r == '0)
    else $error("timer not cleared after reminder");

  // without a reminder the timer only counts up
  a_timer_grows: assert property (@(posedge clk) disable iff (!rst_n)
    take && !remind_c |=> timer_r >= $past(timer_r))
    else $error("timer went backward");

  a_low_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_r.low_event == bml_pkg::EV_WENT_LOW |-> out_r.battery_low)
    else $error("went-low event without low flag");

  a_recover_flag: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_r.low_event == bml_pkg::EV_RECOVERED |-> !out_r.battery_low)
    else $error("recovered event with low flag set");

endmodule
`default_nettype wire
